[hdl/msf_pkg.sv]
package msf_pkg;

  // Width of one node set; fixed by the result format.
  localparam int unsigned MASK_W = 32;
  // Width of a node number on the request channel.
  localparam int unsigned NODE_W = 5;

  typedef logic [MASK_W-1:0] msf_mask_t;

  typedef enum logic [2:0] {
    MSF_COLLECT,
    MSF_DRAIN,
    MSF_LOAD,
    MSF_COMPARE,
    MSF_OUTPUT,
    MSF_FLUSH
  } msf_state_e;

  // A set travelling along the chain (insert probe or compare ring word).
  typedef struct packed {
    logic      valid;
    msf_mask_t mask;
  } msf_probe_t;

  // One stored set and its emission status.
  typedef struct packed {
    logic      valid;
    logic      covered;
    msf_mask_t mask;
  } msf_entry_t;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic load;
    logic rotate;
    logic shift;
  } msf_cell_ctrl_t;

endpackage

[hdl/msf_in_if.sv]
interface msf_in_if;
  logic                         valid;
  logic                         ready;
  logic [msf_pkg::NODE_W-1:0]   node_number;
  logic                         read_ends;
  logic                         batch_ends;

  modport source (output valid, output node_number, output read_ends, output batch_ends,
                  input ready);
  modport sink (input valid, input node_number, input read_ends, input batch_ends,
                output ready);
endinterface

[hdl/msf_out_if.sv]
interface msf_out_if;
  logic                      valid;
  logic                      ready;
  logic [msf_pkg::MASK_W-1:0] node_mask;
  logic                      final_set;
  logic                      overflowed;

  modport source (output valid, output node_mask, output final_set, output overflowed,
                  input ready);
  modport sink (input valid, input node_mask, input final_set, input overflowed,
                output ready);
endinterface

[hdl/maximal_node_set_filter_core.sv]
// Throughput: one node request per cycle while a batch is collected.
// After the request that ends a batch, the chain drains, the ring is loaded,
// the subset check rotates the ring once around the row and the emission
// shift and a flush step follow; the input is held off until the flush is
// done, which takes longer when the result side stalls.
// Reset (rst_ni, asynchronous, active low) empties every cell and clears all control.
module maximal_node_set_filter_core #(
  parameter int unsigned NODES    = 32,
  parameter int unsigned MAX_SETS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  msf_in_if.sink            req_i,
  msf_out_if.source         rsp_o
);

  // The store is a row of MAX_SETS identical cells. Each cell holds one set.
  // Insert probes enter at cell 0 and move one cell per cycle; a probe dies at a
  // cell that holds an equal set or is written into the first empty cell. Since
  // earlier probes always run ahead of later ones, each probe sees every set stored
  // before it, so the cells fill in order of first appearance. A probe that
  // leaves the last cell found the store full and marks the batch as overflowed.
  //
  // At batch end the chain is drained, every cell copies its set into a ring
  // register, and the ring rotates once around the row. Each cell compares the
  // passing sets against its own and flags itself covered when it is a strict
  // subset of another. The entries are then shifted out of cell 0 in order;
  // uncovered ones go to a one-deep hold register so that the last one can be
  // marked as the final set once the shift is done. Shifting empties the store.

  localparam int unsigned CNT_W = $clog2(MAX_SETS + 1);

  msf_pkg::msf_state_e     state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  msf_pkg::msf_mask_t      build_q, build_d;
  logic                    ovf_q, ovf_d;
  logic                    hold_v_q, hold_v_d;
  msf_pkg::msf_mask_t      hold_mask_q, hold_mask_d;
  logic                    out_v_q, out_v_d;
  msf_pkg::msf_mask_t      out_mask_q, out_mask_d;
  logic                    out_final_q, out_final_d;
  logic                    out_ovf_q, out_ovf_d;

  msf_pkg::msf_cell_ctrl_t ctrl;
  msf_pkg::msf_probe_t     probe_head;
  msf_pkg::msf_probe_t     probe_w [MAX_SETS+1];
  msf_pkg::msf_probe_t     ring_w  [MAX_SETS];
  msf_pkg::msf_entry_t     entry_w [MAX_SETS];
  logic [MAX_SETS-1:0]     valid_vec;
  logic [MAX_SETS-1:0]     probe_vec;

  msf_pkg::msf_mask_t      node_bit;
  msf_pkg::msf_mask_t      merged;
  logic                    head_live;
  logic                    out_free;

  // New probes enter the chain at cell 0.
  assign probe_w[0] = probe_head;

  for (genvar k = 0; k < MAX_SETS; k++) begin : g_cell
    msf_pkg::msf_entry_t next_entry;

    if (k == MAX_SETS - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = entry_w[k+1];
    end

    msf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .probe_i (probe_w[k]),
      .probe_o (probe_w[k+1]),
      .ring_i  (ring_w[(k + MAX_SETS - 1) % MAX_SETS]),
      .ring_o  (ring_w[k]),
      .next_i  (next_entry),
      .entry_o (entry_w[k])
    );

    assign valid_vec[k] = entry_w[k].valid;
    assign probe_vec[k] = probe_w[k+1].valid;
  end

  assign req_i.ready      = (state_q == msf_pkg::MSF_COLLECT);
  assign rsp_o.valid      = out_v_q;
  assign rsp_o.node_mask  = out_mask_q;
  assign rsp_o.final_set  = out_final_q;
  assign rsp_o.overflowed = out_ovf_q;

  always_comb begin
    // Nodes at or above NODES add no bit.
    node_bit  = (32'(req_i.node_number) < 32'(NODES)) ?
                (msf_pkg::msf_mask_t'(1) << req_i.node_number) : '0;
    merged    = build_q | node_bit;
    head_live = entry_w[0].valid && !entry_w[0].covered;
    out_free  = !out_v_q || rsp_o.ready;

    state_d     = state_q;
    cnt_d       = cnt_q;
    build_d     = build_q;
    ovf_d       = ovf_q | probe_w[MAX_SETS].valid;
    hold_v_d    = hold_v_q;
    hold_mask_d = hold_mask_q;
    out_v_d     = out_v_q && !rsp_o.ready;
    out_mask_d  = out_mask_q;
    out_final_d = out_final_q;
    out_ovf_d   = out_ovf_q;
    ctrl        = '0;
    probe_head  = '0;

    case (state_q)
      msf_pkg::MSF_COLLECT: begin
        if (req_i.valid) begin
          if (req_i.read_ends) begin
            probe_head.valid = 1'b1;
            probe_head.mask  = merged;
            build_d          = '0;
            if (req_i.batch_ends) begin
              state_d = msf_pkg::MSF_DRAIN;
              cnt_d   = '0;
            end
          end else begin
            build_d = merged;
          end
        end
      end
      msf_pkg::MSF_DRAIN: begin
        // Wait until the last probe has left the tail and its overflow is counted.
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MAX_SETS)) begin
          state_d = msf_pkg::MSF_LOAD;
        end
      end
      msf_pkg::MSF_LOAD: begin
        ctrl.load = 1'b1;
        cnt_d     = '0;
        state_d   = msf_pkg::MSF_COMPARE;
      end
      msf_pkg::MSF_COMPARE: begin
        ctrl.rotate = 1'b1;
        cnt_d       = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MAX_SETS - 1)) begin
          state_d = msf_pkg::MSF_OUTPUT;
          cnt_d   = '0;
        end
      end
      msf_pkg::MSF_OUTPUT: begin
        if (!head_live || !hold_v_q || out_free) begin
          ctrl.shift = 1'b1;
          cnt_d      = cnt_q + CNT_W'(1);
          if (head_live) begin
            hold_v_d    = 1'b1;
            hold_mask_d = entry_w[0].mask;
            if (hold_v_q) begin
              out_v_d     = 1'b1;
              out_mask_d  = hold_mask_q;
              out_final_d = 1'b0;
              out_ovf_d   = ovf_q;
            end
          end
          if (cnt_q == CNT_W'(MAX_SETS - 1)) begin
            state_d = msf_pkg::MSF_FLUSH;
          end
        end
      end
      msf_pkg::MSF_FLUSH: begin
        if (!hold_v_q) begin
          state_d = msf_pkg::MSF_COLLECT;
          ovf_d   = 1'b0;
        end else if (out_free) begin
          out_v_d     = 1'b1;
          out_mask_d  = hold_mask_q;
          out_final_d = 1'b1;
          out_ovf_d   = ovf_q;
          hold_v_d    = 1'b0;
          state_d     = msf_pkg::MSF_COLLECT;
          ovf_d       = 1'b0;
        end
      end
      default: begin
        state_d = msf_pkg::MSF_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= msf_pkg::MSF_COLLECT;
      cnt_q    <= '0;
      build_q  <= '0;
      ovf_q    <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      build_q  <= build_d;
      ovf_q    <= ovf_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_mask_q <= hold_mask_d;
    out_mask_q  <= out_mask_d;
    out_final_q <= out_final_d;
    out_ovf_q   <= out_ovf_d;
  end

`ifndef SYNTHESIS
  // Stored sets always occupy a contiguous run of cells starting at cell 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + MAX_SETS'(1))) == '0)
    else $error("stored sets are not contiguous");

  // No insert probe may still travel once the subset check has started.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != msf_pkg::MSF_COLLECT && state_q != msf_pkg::MSF_DRAIN) |-> probe_vec == '0)
    else $error("insert probe alive after drain");

  // The store is empty when a new batch begins.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msf_pkg::MSF_COLLECT && $past(state_q) == msf_pkg::MSF_FLUSH)
      |-> valid_vec == '0)
    else $error("store not empty at start of batch");

  // The hold register is always flushed before collecting resumes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == msf_pkg::MSF_COLLECT |-> !hold_v_q)
    else $error("held set left behind at batch end");
`endif

endmodule

[hdl/msf_cell.sv]
module msf_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  msf_pkg::msf_cell_ctrl_t ctrl_i,
  input  msf_pkg::msf_probe_t     probe_i,
  output msf_pkg::msf_probe_t     probe_o,
  input  msf_pkg::msf_probe_t     ring_i,
  output msf_pkg::msf_probe_t     ring_o,
  input  msf_pkg::msf_entry_t     next_i,
  output msf_pkg::msf_entry_t     entry_o
);

  msf_pkg::msf_entry_t entry_q, entry_d;
  msf_pkg::msf_probe_t probe_q, probe_d;
  msf_pkg::msf_probe_t ring_q, ring_d;

  logic probe_hit;
  logic take;
  logic strict_sub;

  always_comb begin
    // An equal stored set absorbs the probe; the first empty cell takes it.
    probe_hit  = probe_i.valid && entry_q.valid && (probe_i.mask == entry_q.mask);
    take       = probe_i.valid && !entry_q.valid;
    // Our set is a strict subset of the passing ring word.
    strict_sub = ring_i.valid && entry_q.valid && (ring_i.mask != entry_q.mask) &&
                 ((entry_q.mask | ring_i.mask) == ring_i.mask);

    entry_d = entry_q;
    ring_d  = ring_q;

    if (ctrl_i.shift) begin
      entry_d = next_i;
    end else if (take) begin
      entry_d.valid   = 1'b1;
      entry_d.covered = 1'b0;
      entry_d.mask    = probe_i.mask;
    end

    if (ctrl_i.load) begin
      ring_d.valid    = entry_q.valid;
      ring_d.mask     = entry_q.mask;
      entry_d.covered = 1'b0;
    end else if (ctrl_i.rotate) begin
      ring_d = ring_i;
      if (strict_sub) begin
        entry_d.covered = 1'b1;
      end
    end

    probe_d.valid = probe_i.valid && !probe_hit && !take;
    probe_d.mask  = probe_i.mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      probe_q <= '0;
      ring_q  <= '0;
    end else begin
      entry_q <= entry_d;
      probe_q <= probe_d;
      ring_q  <= ring_d;
    end
  end

  assign probe_o = probe_q;
  assign ring_o  = ring_q;
  assign entry_o = entry_q;

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

// Self-checking bench for the maximal node set filter. Requests (one graph
// node each) are sent on the request channel and every result on the result
// channel is matched against a local model of the filter that is advanced on
// each accepted request.
module testbench;

  localparam int unsigned NODES_P    = 32;
  localparam int unsigned MAX_SETS_P = 64;

  typedef logic [msf_pkg::NODE_W-1:0] node_t;

  // Sender and receiver idling for one phase of the run.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  localparam int unsigned SOLO_IDLE_PCT = 52;
  localparam int unsigned BOTH_IDLE_PCT = 35;

  // The receiver holds off this long once, while the sender keeps offering.
  localparam int unsigned HOLD_CYCLES = 400;
  // Covers the drain, ring load, subset check, emission shift and flush after a
  // batch end until the last set leaves when the result side keeps up.
  localparam int unsigned SETTLE_CYCLES = 3 * MAX_SETS_P + 20;
  // Cycles with no handshake on either side before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned PHASE_REQUESTS = 60;

  typedef struct packed {
    msf_pkg::msf_mask_t mask;
    logic               final_set;
    logic               overflowed;
  } set_result_t;

  // One directed request. Where typed is set, the listed result is the only
  // one this request may cause; otherwise the local model decides.
  typedef struct packed {
    node_t              node;
    logic               read_end;
    logic               batch_end;
    logic               typed;
    msf_pkg::msf_mask_t mask;
    logic               final_set;
    logic               overflowed;
  } directed_row_t;

  localparam int DIRECTED_N = 19;
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    // Lowest node alone in a one-read batch.
    '{5'd0,  1'b1, 1'b1, 1'b1, 32'h0000_0001, 1'b1, 1'b0},
    // Highest node alone in a one-read batch.
    '{5'd31, 1'b1, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 1'b0},
    // A batch end flag without a read end must be ignored.
    '{5'd5,  1'b0, 1'b1, 1'b0, 32'h0,         1'b0, 1'b0},
    '{5'd5,  1'b1, 1'b1, 1'b1, 32'h0000_0020, 1'b1, 1'b0},
    // The same node repeated within one read sets one bit.
    '{5'd4,  1'b0, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{5'd4,  1'b0, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{5'd4,  1'b1, 1'b1, 1'b1, 32'h0000_0010, 1'b1, 1'b0},
    // Two equal reads collapse into one stored set.
    '{5'd7,  1'b1, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{5'd7,  1'b1, 1'b1, 1'b1, 32'h0000_0080, 1'b1, 1'b0},
    // Duplicates, a strict subset and a disjoint set in one batch.
    '{5'd1,  1'b0, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{5'd2,  1'b1, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{5'd1,  1'b1, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{5'd2,  1'b0, 1'b1, 1'b0, 32'h0,         1'b0, 1'b0},
    '{5'd1,  1'b1, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{5'd3,  1'b1, 1'b1, 1'b0, 32'h0,         1'b0, 1'b0},
    // Two single sets both covered by their union: only the union survives.
    '{5'd10, 1'b1, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{5'd20, 1'b1, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{5'd10, 1'b0, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{5'd20, 1'b1, 1'b1, 1'b1, 32'h0010_0400, 1'b1, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  msf_in_if  req_if ();
  msf_out_if rsp_if ();

  maximal_node_set_filter_core #(
    .NODES    (NODES_P),
    .MAX_SETS (MAX_SETS_P)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Local model of the filter: the distinct sets of the open batch in order
  // of first appearance, the read under construction and the overflow flag.
  msf_pkg::msf_mask_t seen_sets [$];
  msf_pkg::msf_mask_t open_read_mask;
  logic               sets_dropped;
  // Results caused by the latest request, then the results still awaited.
  set_result_t batch_maximal [$];
  set_result_t maximal_sets_due [$];

  idle_mode_e  idle_mode;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned requests_sent;
  int          error_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Emits every stored set that no other stored set strictly contains. The
  // last emitted set of the batch carries the final flag.
  function automatic void collect_maximal_sets();
    logic covered;
    batch_maximal.delete();
    for (int i = 0; i < seen_sets.size(); i++) begin
      covered = 1'b0;
      for (int j = 0; j < seen_sets.size(); j++) begin
        if (j != i && seen_sets[j] != seen_sets[i] &&
            (seen_sets[i] | seen_sets[j]) == seen_sets[j]) begin
          covered = 1'b1;
        end
      end
      if (!covered) begin
        batch_maximal.insert(batch_maximal.size(),
                             set_result_t'{mask: seen_sets[i], final_set: 1'b0,
                                           overflowed: sets_dropped});
      end
    end
    if (batch_maximal.size() != 0) begin
      batch_maximal[batch_maximal.size()-1].final_set = 1'b1;
    end
  endfunction

  // Advances the model by one accepted request and leaves its results, if
  // any, in batch_maximal.
  function automatic void filter_node_request(input node_t node,
                                              input logic read_end,
                                              input logic batch_end);
    logic known;
    batch_maximal.delete();
    if (node < NODES_P) begin
      open_read_mask = open_read_mask | (msf_pkg::msf_mask_t'(1) << node);
    end
    if (read_end) begin
      known = 1'b0;
      foreach (seen_sets[k]) begin
        if (seen_sets[k] == open_read_mask) begin
          known = 1'b1;
        end
      end
      if (!known) begin
        if (seen_sets.size() < MAX_SETS_P) begin
          seen_sets.insert(seen_sets.size(), open_read_mask);
        end else begin
          sets_dropped = 1'b1;
        end
      end
      open_read_mask = '0;
      // The batch end flag only counts on the last node of a read.
      if (batch_end) begin
        collect_maximal_sets();
        seen_sets.delete();
        sets_dropped = 1'b0;
      end
    end
  endfunction

  function automatic int unsigned sender_idle_pct();
    case (idle_mode)
      IDLE_SENDER: return SOLO_IDLE_PCT;
      IDLE_BOTH:   return BOTH_IDLE_PCT;
      default:     return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case (idle_mode)
      IDLE_RECEIVER: return SOLO_IDLE_PCT;
      IDLE_BOTH:     return BOTH_IDLE_PCT;
      default:       return 0;
    endcase
  endfunction

  // Offers one request and returns at the edge where it is accepted. Valid
  // stays high afterwards, so back-to-back requests need no extra edge.
  task automatic send_request(input node_t node,
                              input logic read_end,
                              input logic batch_end,
                              input logic typed,
                              input set_result_t typed_result);
    int unsigned idle_pct;
    idle_pct = sender_idle_pct();
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.node_number <= node;
    req_if.read_ends   <= read_end;
    req_if.batch_ends  <= batch_end;
    @(posedge clk_i);
    while (!req_if.ready) begin
      @(posedge clk_i);
    end
    requests_sent++;
    filter_node_request(node, read_end, batch_end);
    if (typed) begin
      maximal_sets_due.insert(maximal_sets_due.size(), typed_result);
    end else begin
      foreach (batch_maximal[k]) begin
        maximal_sets_due.insert(maximal_sets_due.size(), batch_maximal[k]);
      end
    end
  endtask

  // Sends one batch of random reads. Nodes come from a window of random
  // width and position: narrow windows give many duplicates and subsets,
  // the full window gives mostly incomparable sets. Nodes that do not end a
  // read sometimes carry a stray batch end flag, which must be ignored.
  task automatic send_random_batch(input int unsigned reads,
                                   input int unsigned most_nodes);
    int unsigned span;
    int unsigned base;
    int unsigned count;
    logic        last_node;
    case ($urandom_range(0, 2))
      0:       span = 3;
      1:       span = 7;
      default: span = 31;
    endcase
    base = $urandom_range(0, 31 - span);
    for (int r = 0; r < reads; r++) begin
      count = $urandom_range(1, most_nodes);
      for (int n = 0; n < count; n++) begin
        last_node = (n == count - 1);
        send_request(node_t'(base + $urandom_range(0, span)), last_node,
                     last_node ? (r == reads - 1) : ($urandom_range(0, 7) == 0),
                     1'b0, '0);
      end
    end
  endtask

  // Reads of two distinct nodes: such sets never contain one another, so
  // every stored set is emitted and the store runs past its capacity.
  task automatic send_overflow_batch(input int unsigned reads);
    int unsigned first_node;
    for (int r = 0; r < reads; r++) begin
      first_node = $urandom_range(0, 31);
      send_request(node_t'(first_node), 1'b0, 1'b0, 1'b0, '0);
      send_request(node_t'((first_node + $urandom_range(1, 31)) % 32), 1'b1,
                   r == reads - 1, 1'b0, '0);
    end
  endtask

  // Drops valid and waits until every result of the sent batches is in.
  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (maximal_sets_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Result side: ready is redrawn every cycle, except during a requested
  // hold-off, which this process counts down itself.
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served   <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      rsp_if.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      rsp_if.ready  <= 1'b0;
    end else begin
      rsp_if.ready  <= !($urandom_range(0, 99) < receiver_stall_pct());
    end
  end

  // Every accepted result is matched against the oldest awaited one.
  always @(posedge clk_i) begin
    set_result_t due;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (maximal_sets_due.size() == 0) begin
        $display("%0t: unexpected result mask=%h final=%b overflow=%b", $time,
                 rsp_if.node_mask, rsp_if.final_set, rsp_if.overflowed);
        error_count++;
      end else begin
        due = maximal_sets_due.pop_front();
        if (rsp_if.node_mask !== due.mask) begin
          $display("%0t: node_mask expected %h actual %h", $time, due.mask,
                   rsp_if.node_mask);
          error_count++;
        end
        if (rsp_if.final_set !== due.final_set) begin
          $display("%0t: final_set expected %b actual %b (mask %h)", $time,
                   due.final_set, rsp_if.final_set, due.mask);
          error_count++;
        end
        if (rsp_if.overflowed !== due.overflowed) begin
          $display("%0t: overflowed expected %b actual %b (mask %h)", $time,
                   due.overflowed, rsp_if.overflowed, due.mask);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung block shows as a long run of cycles without any
  // handshake on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    set_result_t row_result;
    seen_sets.delete();
    open_read_mask = '0;
    sets_dropped   = 1'b0;
    error_count    = 0;
    requests_sent  = 0;
    hold_requests  = 0;
    idle_mode      = IDLE_NONE;
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.node_number <= '0;
    req_if.read_ends   <= 1'b0;
    req_if.batch_ends  <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, without idling.
    for (int i = 0; i < DIRECTED_N; i++) begin
      row_result = '{mask: DIRECTED_ROWS[i].mask,
                     final_set: DIRECTED_ROWS[i].final_set,
                     overflowed: DIRECTED_ROWS[i].overflowed};
      send_request(DIRECTED_ROWS[i].node, DIRECTED_ROWS[i].read_end,
                   DIRECTED_ROWS[i].batch_end, DIRECTED_ROWS[i].typed, row_result);
    end
    wait_results_drained();

    // Random batches under each idling pattern; the sender pauses between
    // phases until every set of the previous phase has come back.
    for (int m = 0; m < 4; m++) begin
      idle_mode <= idle_mode_e'(m);
      @(posedge clk_i);
      requests_sent = 0;
      while (requests_sent < PHASE_REQUESTS) begin
        send_random_batch($urandom_range(1, 8), $urandom_range(1, 4));
      end
      wait_results_drained();
    end

    // The result side holds off while a batch that overflows the store is
    // sent, followed by more requests, so the block backs up onto its input.
    // The batch after it must come out with the overflow flag cleared.
    idle_mode <= IDLE_NONE;
    hold_requests <= hold_requests + 1;
    @(posedge clk_i);
    send_overflow_batch(80);
    send_random_batch(4, 3);
    send_random_batch($urandom_range(2, 6), 4);
    wait_results_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (maximal_sets_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, maximal_sets_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
